### hdl/nes_pkg.sv
// shared types and constants of the note envelope sequencer
package nes_pkg;

  localparam int OUT_ENVS = 7;
  localparam int KIND_W = 3;
  localparam int ENV_ID_W = 3;
  localparam int PHASE_W = 2;
  localparam int VALUE_W = 16;
  localparam int ENTRY_W = 8;
  localparam int MASK_W = 7;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int TICKS_W = 11;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_BYTE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_DESC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP      = 3'd4;

  // note phases
  localparam logic [PHASE_W-1:0] PHASE_OFF      = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_HELD     = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_RELEASED = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_UNSIGNED_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_INDEX  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_INDEX   = 2'd2;

  localparam logic [MASK_W-1:0]   MASK_RESET  = 7'd9;
  localparam logic [ENV_ID_W-1:0] VOL_RESET   = 3'd0;
  localparam logic [ENV_ID_W-1:0] PITCH_RESET = 3'd2;
  localparam logic [VALUE_W-1:0]  VOL_DEFAULT = 16'd255;

  typedef struct packed {
    logic [MASK_W-1:0]   unsigned_mask;
    logic [ENV_ID_W-1:0] volume_env_index;
    logic [ENV_ID_W-1:0] pitch_rel_index;
  } nes_cfg_t;

  typedef struct packed {
    logic       on;
    logic [6:0] len;
    logic [5:0] loop;
    logic [6:0] rel;
  } nes_desc_t;

  typedef struct packed {
    logic                en;
    logic [ENV_ID_W-1:0] id;
    nes_desc_t           desc;
  } nes_desc_wr_t;

  typedef struct packed {
    logic                issue;
    logic                rewind;
    logic [ENV_ID_W-1:0] env;
    logic [PHASE_W-1:0]  phase;
  } nes_seq_t;

endpackage

### hdl/nes_ram.sv
// generic single-clock ram with one write port and one registered read port
module nes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 448
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/nes_env_path.sv
// envelope datapath: descriptors, cursors, values, step logic and write-back stage
module nes_env_path #(
  parameter int ENV_COUNT = 7,
  parameter int MAX_ENV_LEN = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  nes_pkg::nes_cfg_t                      cfg,
  input  nes_pkg::nes_desc_wr_t                  desc_wr,
  input  nes_pkg::nes_seq_t                      seq,
  output logic                                   ram_re,
  output logic [$clog2(ENV_COUNT*MAX_ENV_LEN)-1:0] ram_raddr,
  input  logic [nes_pkg::ENTRY_W-1:0]            ram_rdata,
  output logic [nes_pkg::VALUE_W-1:0]            values [ENV_COUNT]
);
  import nes_pkg::*;

  localparam int EW = (ENV_COUNT > 1) ? $clog2(ENV_COUNT) : 1;
  localparam int AW = $clog2(ENV_COUNT * MAX_ENV_LEN);
  localparam int CW = $clog2(MAX_ENV_LEN + 1);
  localparam int KW = ((CW > 7) ? CW : 7) + 1;

  typedef enum logic [1:0] {
    WB_CURSOR = 2'd0,
    WB_LOAD   = 2'd1,
    WB_ADD    = 2'd2,
    WB_CONST  = 2'd3
  } wb_op_t;

  nes_desc_t         desc_r  [ENV_COUNT];
  logic [CW-1:0]      cur_r   [ENV_COUNT];
  logic [VALUE_W-1:0] value_r [ENV_COUNT];

  logic               pend_valid_r;
  logic [ENV_ID_W-1:0] pend_env_r;
  logic [CW-1:0]      pend_cur_r;
  wb_op_t             pend_op_r;
  logic [VALUE_W-1:0] pend_const_r;

  logic               iss_valid;
  logic [CW-1:0]      iss_cur;
  wb_op_t             iss_op;
  logic [VALUE_W-1:0] iss_const;
  logic [KW-1:0]      rd_pos;

  nes_desc_t          d;
  logic [KW-1:0]      len_k, cur_k, nc, rel_k, loop_k, tgt;
  logic               held, is_pitch, is_vol;

  logic [7:0]         mask8;
  logic [VALUE_W-1:0] ext;
  logic signed [VALUE_W:0] sum;
  logic [VALUE_W-1:0] sat;

  always_comb begin
    d        = desc_r[seq.env[EW-1:0]];
    cur_k    = KW'(cur_r[seq.env[EW-1:0]]);
    len_k    = KW'(d.len);
    if (len_k == '0) begin
      len_k = KW'(1);
    end
    if (len_k > KW'(MAX_ENV_LEN)) begin
      len_k = KW'(MAX_ENV_LEN);
    end
    nc       = cur_k + KW'(1);
    rel_k    = KW'(d.rel);
    loop_k   = KW'(d.loop);
    held     = (seq.phase == PHASE_HELD);
    is_pitch = (4'(seq.env) == 4'(cfg.pitch_rel_index));
    is_vol   = (4'(seq.env) == 4'(cfg.volume_env_index));
    tgt      = nc;

    iss_valid = 1'b0;
    iss_cur   = cur_r[seq.env[EW-1:0]];
    iss_op    = WB_CURSOR;
    iss_const = '0;
    rd_pos    = '0;
    ram_re    = 1'b0;

    if (seq.issue) begin
      if (seq.rewind) begin
        iss_valid = 1'b1;
        iss_cur   = '0;
        if (d.on) begin
          iss_op = WB_LOAD;
          ram_re = 1'b1;
        end else begin
          iss_op    = WB_CONST;
          iss_const = is_vol ? VOL_DEFAULT : '0;
        end
      end else if (d.on) begin
        if (is_pitch) begin
          // accumulating envelope stops once the cursor reaches the length
          if (cur_k < len_k) begin
            iss_valid = 1'b1;
            iss_cur   = CW'(nc);
            if (nc < len_k) begin
              iss_op = WB_ADD;
              ram_re = 1'b1;
              rd_pos = nc;
            end
          end
        end else begin
          if ((held && nc >= rel_k) || nc >= len_k) begin
            if (held) begin
              tgt = (loop_k >= len_k) ? len_k - KW'(1) : loop_k;
            end else begin
              tgt = len_k - KW'(1);
            end
          end
          iss_valid = 1'b1;
          iss_cur   = CW'(tgt);
          iss_op    = WB_LOAD;
          ram_re    = 1'b1;
          rd_pos    = tgt;
        end
      end
    end
    ram_raddr = AW'(32'(seq.env) * MAX_ENV_LEN + 32'(rd_pos));
  end

  // write-back side: raw byte from the ram, sign handling, pitch saturation
  always_comb begin
    mask8 = {1'b0, cfg.unsigned_mask};
    if (mask8[pend_env_r]) begin
      ext = {8'd0, ram_rdata};
    end else begin
      ext = {{8{ram_rdata[7]}}, ram_rdata};
    end
    sum = $signed({value_r[pend_env_r[EW-1:0]][VALUE_W-1], value_r[pend_env_r[EW-1:0]]})
        + $signed({ext[VALUE_W-1], ext});
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      sat = sum[VALUE_W] ? 16'h8000 : 16'h7fff;
    end else begin
      sat = sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= iss_valid;
    end
    pend_env_r   <= seq.env;
    pend_cur_r   <= iss_cur;
    pend_op_r    <= iss_op;
    pend_const_r <= iss_const;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENV_COUNT; e++) begin
        desc_r[e]  <= '0;
        cur_r[e]   <= '0;
        value_r[e] <= (4'(e) == 4'(VOL_RESET)) ? VOL_DEFAULT : '0;
      end
    end else begin
      if (desc_wr.en) begin
        desc_r[desc_wr.id[EW-1:0]] <= desc_wr.desc;
      end
      if (pend_valid_r) begin
        cur_r[pend_env_r[EW-1:0]] <= pend_cur_r;
        case (pend_op_r)
          WB_LOAD:  value_r[pend_env_r[EW-1:0]] <= ext;
          WB_ADD:   value_r[pend_env_r[EW-1:0]] <= sat;
          WB_CONST: value_r[pend_env_r[EW-1:0]] <= pend_const_r;
          default:  ;
        endcase
      end
    end
  end

  assign values = value_r;

endmodule

### hdl/note_envelope_sequencer.sv
// note envelope sequencer top level: note timer, item sequencer, entry ram and result register
// order: load, stop, unknown and plain note-on requests go from acceptance straight to the result
//   register; stepping ticks and attacks first step every envelope, then load the result
// throughput: one request at a time, intake stays closed until the result is loaded; the envelopes
//   are stepped through the single entry ram read port that serves one envelope per cycle
// reset: synchronous active-low rst_n sets the timer, phase, descriptors, cursors, values and
//   config registers to their defaults; the entry ram is not cleared
module note_envelope_sequencer #(
  parameter int ENV_COUNT = 7,
  parameter int MAX_ENV_LEN = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // env_id, position, entry_byte, env_enable, env_length, loop_point, release_point,
  // release_ticks, duration_ticks, attack, zero fill
  input  logic [nes_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind
  input  logic [nes_pkg::KIND_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // note_phase, env_value_0 .. env_value_6, zero fill
  output logic [nes_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nes_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nes_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nes_pkg::*;

  localparam int AW = $clog2(ENV_COUNT * MAX_ENV_LEN);
  localparam int NW = $clog2(ENV_COUNT + 1);
  localparam int FILL_W = OUT_DATA_W - PHASE_W - OUT_ENVS * VALUE_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TICKS_W-1:0] dur_r, dur_nxt;
  logic [TICKS_W-1:0] rel_r, rel_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic               rewind_r, rewind_nxt;
  nes_cfg_t           cfg_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [ENV_ID_W-1:0] f_env_id;
  logic [5:0]          f_position;
  logic [ENTRY_W-1:0]  f_entry;
  nes_desc_t           f_desc;
  logic [TICKS_W-1:0]  f_release, f_duration;
  logic                f_attack;
  logic                in_acc;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  nes_desc_wr_t        desc_wr;
  nes_seq_t            seq;
  logic [VALUE_W-1:0]  values [ENV_COUNT];
  logic [OUT_DATA_W-1:0] out_pack;
  logic                out_load;

  assign f_env_id    = in_tdata[2:0];
  assign f_position  = in_tdata[8:3];
  assign f_entry     = in_tdata[16:9];
  assign f_desc.on   = in_tdata[17];
  assign f_desc.len  = in_tdata[24:18];
  assign f_desc.loop = in_tdata[30:25];
  assign f_desc.rel  = in_tdata[37:31];
  assign f_release   = in_tdata[48:38];
  assign f_duration  = in_tdata[59:49];
  assign f_attack    = in_tdata[60];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    dur_nxt    = dur_r;
    rel_nxt    = rel_r;
    cnt_nxt    = cnt_r;
    rewind_nxt = rewind_r;
    ram_we     = 1'b0;
    desc_wr.en = 1'b0;
    desc_wr.id   = f_env_id;
    desc_wr.desc = f_desc;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_FINISH;
          cnt_nxt   = '0;
          case (in_tuser)
            KIND_LOAD_BYTE: begin
              ram_we = (32'(f_env_id) < ENV_COUNT) && (32'(f_position) < MAX_ENV_LEN);
            end
            KIND_LOAD_DESC: begin
              desc_wr.en = (32'(f_env_id) < ENV_COUNT);
            end
            KIND_NOTE_ON: begin
              rel_nxt   = f_release;
              dur_nxt   = f_duration;
              phase_nxt = PHASE_HELD;
              if (f_attack) begin
                state_nxt  = ST_RUN;
                rewind_nxt = 1'b1;
              end
            end
            KIND_TICK: begin
              if (phase_r != PHASE_OFF) begin
                if (dur_r <= TICKS_W'(1)) begin
                  dur_nxt   = '0;
                  phase_nxt = PHASE_OFF;
                end else begin
                  dur_nxt = dur_r - TICKS_W'(1);
                  if (rel_r != '0) begin
                    rel_nxt = rel_r - TICKS_W'(1);
                    if (rel_r == TICKS_W'(1)) begin
                      phase_nxt = PHASE_RELEASED;
                    end
                  end
                  state_nxt  = ST_RUN;
                  rewind_nxt = 1'b0;
                end
              end
            end
            KIND_STOP: begin
              phase_nxt = PHASE_OFF;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // one envelope read per cycle, its write-back lands in the following cycle
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(ENV_COUNT)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ram_waddr    = AW'(32'(f_env_id) * MAX_ENV_LEN + 32'(f_position));

  assign seq.issue  = (state_r == ST_RUN) && (cnt_r < NW'(ENV_COUNT));
  assign seq.rewind = rewind_r;
  assign seq.env    = ENV_ID_W'(cnt_r);
  assign seq.phase  = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PHASE_OFF;
      dur_r    <= '0;
      rel_r    <= '0;
      cnt_r    <= '0;
      rewind_r <= 1'b0;
      cfg_r.unsigned_mask    <= MASK_RESET;
      cfg_r.volume_env_index <= VOL_RESET;
      cfg_r.pitch_rel_index  <= PITCH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      dur_r    <= dur_nxt;
      rel_r    <= rel_nxt;
      cnt_r    <= cnt_nxt;
      rewind_r <= rewind_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UNSIGNED_MASK: cfg_r.unsigned_mask    <= cfg_data[MASK_W-1:0];
          REG_VOLUME_INDEX:  cfg_r.volume_env_index <= cfg_data[ENV_ID_W-1:0];
          REG_PITCH_INDEX:   cfg_r.pitch_rel_index  <= cfg_data[ENV_ID_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_data_r <= out_pack;
    end
  end

  // result fields beyond the envelope count stay zero
  for (genvar e = 0; e < OUT_ENVS; e++) begin : g_pack
    if (e < ENV_COUNT) begin : g_env
      logic [VALUE_W-1:0] v;
      assign v = values[e];
    end
  end

  logic [OUT_ENVS*VALUE_W-1:0] env_flat;
  for (genvar e = 0; e < OUT_ENVS; e++) begin : g_flat
    if (e < ENV_COUNT) begin : g_on
      assign env_flat[e*VALUE_W +: VALUE_W] = g_pack[e].g_env.v;
    end else begin : g_off
      assign env_flat[e*VALUE_W +: VALUE_W] = '0;
    end
  end

  // envelope fields follow the phase in the result word
  assign out_pack = {FILL_W'(0), env_flat, phase_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[OUT_DATA_W-1:PHASE_W+OUT_ENVS*VALUE_W],
                       out_data_r[PHASE_W+OUT_ENVS*VALUE_W-1:0]};

  nes_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENV_COUNT * MAX_ENV_LEN)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (f_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nes_env_path #(
    .ENV_COUNT   (ENV_COUNT),
    .MAX_ENV_LEN (MAX_ENV_LEN)
  ) u_env_path (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .desc_wr   (desc_wr),
    .seq       (seq),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .values    (values)
  );

endmodule

### hdl/nes_checker.sv
// port-level checker for the note envelope sequencer, bound to the top level
module nes_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [nes_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [nes_pkg::KIND_W-1:0]     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [nes_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [nes_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [nes_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nes_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: intake closes right after a request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in work");

  // a new result is only loaded while intake is closed
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a request in work");

  // the phase field never carries the unused code
  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PHASE_W-1:0] == PHASE_OFF ||
                    out_tdata[PHASE_W-1:0] == PHASE_HELD ||
                    out_tdata[PHASE_W-1:0] == PHASE_RELEASED))
    else $error("bad note phase code");

endmodule

bind note_envelope_sequencer nes_checker u_nes_checker (.*);

### verif/tb_note_envelope_sequencer.sv
// self-checking testbench for the note envelope sequencer: directed script, then random phrases
`timescale 1ns / 1ps

module tb_note_envelope_sequencer;
  import nes_pkg::*;

  localparam int ENVS = 7;
  localparam int LEN = 64;
  localparam int PHRASE_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int LONG_STALL = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = KIND_STOP + 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST = '1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ENV_ID_W-1:0] env_id;
    logic [5:0]          position;
    logic [ENTRY_W-1:0]  entry_byte;
    logic                env_enable;
    logic [6:0]          env_length;
    logic [5:0]          loop_point;
    logic [6:0]          release_point;
    logic [TICKS_W-1:0]  release_ticks;
    logic [TICKS_W-1:0]  duration_ticks;
    logic                attack;
  } voice_req_t;

  typedef struct {
    voice_req_t            req;
    bit                    has_view;
    logic [OUT_DATA_W-1:0] view;
  } script_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [KIND_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  note_envelope_sequencer #(
    .ENV_COUNT(ENVS),
    .MAX_ENV_LEN(LEN)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // voice predictor state
  logic [MASK_W-1:0]   pred_mask;
  logic [ENV_ID_W-1:0] pred_vol_sel;
  logic [ENV_ID_W-1:0] pred_pitch_sel;
  logic [PHASE_W-1:0]  voice_phase;
  int                  dur_left;
  int                  rel_left;
  logic [7:0]          voice_entries [ENVS*LEN];
  nes_desc_t           env_desc [ENVS];
  int                  env_cursor [ENVS];
  int                  env_level [ENVS];

  logic [OUT_DATA_W-1:0] pending_views [$];
  script_row_t           script_rows [$];
  int  requests_sent;
  int  results_checked;
  int  fail_count;
  int  settings_used;
  int  notes_started;
  int  releases_seen;
  int  expiries_seen;
  bit  steady_sender;
  bit  stall_wanted;
  bit  stall_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_checked, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic voice_reset();
    pred_mask = MASK_RESET;
    pred_vol_sel = VOL_RESET;
    pred_pitch_sel = PITCH_RESET;
    voice_phase = PHASE_OFF;
    dur_left = 0;
    rel_left = 0;
    for (int e = 0; e < ENVS; e++) begin
      env_desc[e] = '0;
      env_cursor[e] = 0;
      env_level[e] = (e == int'(VOL_RESET)) ? int'(VOL_DEFAULT) : 0;
    end
    for (int i = 0; i < ENVS * LEN; i++) voice_entries[i] = '0;
  endtask

  function automatic int entry_value(input int e, input int pos);
    logic [7:0] b;
    b = voice_entries[e * LEN + pos];
    if (!pred_mask[e] && b[7]) return int'(b) - 256;
    return int'(b);
  endfunction

  function automatic int effective_length(input int e);
    int l;
    l = int'(env_desc[e].len);
    if (l == 0) l = 1;
    if (l > LEN) l = LEN;
    return l;
  endfunction

  function automatic void rewind_envelopes();
    for (int e = 0; e < ENVS; e++) begin
      env_cursor[e] = 0;
      env_level[e] = (e == int'(pred_vol_sel)) ? int'(VOL_DEFAULT) : 0;
      if (env_desc[e].on) env_level[e] = entry_value(e, 0);
    end
  endfunction

  function automatic void advance_envelope(input int e);
    int len;
    int cur;
    int sum;
    len = effective_length(e);
    cur = env_cursor[e];
    if (e == int'(pred_pitch_sel)) begin
      // relative pitch runs once to its end and then sticks
      if (cur >= len) return;
      cur++;
      if (cur < len) begin
        sum = env_level[e] + entry_value(e, cur);
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        env_level[e] = sum;
      end
    end else begin
      cur++;
      if ((voice_phase == PHASE_HELD && cur >= int'(env_desc[e].rel)) || cur >= len) begin
        if (voice_phase == PHASE_HELD) begin
          cur = int'(env_desc[e].loop);
          if (cur >= len) cur = len - 1;
        end else begin
          cur = len - 1;
        end
      end
      env_level[e] = entry_value(e, cur);
    end
    env_cursor[e] = cur;
  endfunction

  function automatic void count_down_tick();
    if (voice_phase == PHASE_OFF) return;
    if (dur_left <= 1) begin
      dur_left = 0;
      voice_phase = PHASE_OFF;
      expiries_seen++;
      return;
    end
    dur_left--;
    if (rel_left > 0) begin
      rel_left--;
      if (rel_left == 0) begin
        voice_phase = PHASE_RELEASED;
        releases_seen++;
      end
    end
    for (int e = 0; e < ENVS; e++)
      if (env_desc[e].on) advance_envelope(e);
  endfunction

  function automatic logic [OUT_DATA_W-1:0] voice_apply(input voice_req_t r);
    logic [OUT_DATA_W-1:0] view;
    case (r.kind)
      KIND_LOAD_BYTE: begin
        if (int'(r.env_id) < ENVS)
          voice_entries[int'(r.env_id) * LEN + int'(r.position)] = r.entry_byte;
      end
      KIND_LOAD_DESC: begin
        if (int'(r.env_id) < ENVS)
          env_desc[r.env_id] = {r.env_enable, r.env_length, r.loop_point, r.release_point};
      end
      KIND_NOTE_ON: begin
        rel_left = int'(r.release_ticks);
        dur_left = int'(r.duration_ticks);
        voice_phase = PHASE_HELD;
        notes_started++;
        if (r.attack) rewind_envelopes();
      end
      KIND_TICK: count_down_tick();
      KIND_STOP: voice_phase = PHASE_OFF;
      default: ;
    endcase
    view = '0;
    view[PHASE_W-1:0] = voice_phase;
    for (int e = 0; e < ENVS; e++) view[PHASE_W + VALUE_W * e +: VALUE_W] = env_level[e][15:0];
    return view;
  endfunction

  // ------------------------------------------------------------ request helpers

  function automatic voice_req_t any_req(input logic [KIND_W-1:0] kind);
    voice_req_t r;
    r = {$urandom, $urandom};
    r.kind = kind;
    return r;
  endfunction

  function automatic voice_req_t note_req(input int rel, input int dur, input bit att);
    voice_req_t r;
    r = any_req(KIND_NOTE_ON);
    r.release_ticks = TICKS_W'(rel);
    r.duration_ticks = TICKS_W'(dur);
    r.attack = att;
    return r;
  endfunction

  function automatic voice_req_t desc_req(input int id, input bit en, input int len,
                                          input int lp, input int rel);
    voice_req_t r;
    r = any_req(KIND_LOAD_DESC);
    r.env_id = ENV_ID_W'(id);
    r.env_enable = en;
    r.env_length = 7'(len);
    r.loop_point = 6'(lp);
    r.release_point = 7'(rel);
    return r;
  endfunction

  function automatic voice_req_t byte_req(input int id, input int pos, input logic [7:0] b);
    voice_req_t r;
    r = any_req(KIND_LOAD_BYTE);
    r.env_id = ENV_ID_W'(id);
    r.position = 6'(pos);
    r.entry_byte = b;
    return r;
  endfunction

  // result seen right after reset: only the volume envelope holds its default
  function automatic logic [OUT_DATA_W-1:0] idle_view(input logic [PHASE_W-1:0] ph);
    logic [OUT_DATA_W-1:0] v;
    v = '0;
    v[PHASE_W-1:0] = ph;
    v[PHASE_W +: VALUE_W] = VOL_DEFAULT;
    return v;
  endfunction

  function automatic void add_row(input voice_req_t r, input bit typed,
                                  input logic [PHASE_W-1:0] ph);
    script_row_t row;
    row.req = r;
    row.has_view = typed;
    row.view = idle_view(ph);
    script_rows.push_back(row);
  endfunction

  function automatic void build_script();
    // rows typed by hand: reset state, nothing enabled yet
    add_row(any_req(KIND_UNUSED_LAST), 1'b1, PHASE_OFF);
    add_row(any_req(KIND_UNUSED_FIRST), 1'b1, PHASE_OFF);
    add_row(any_req(KIND_TICK), 1'b1, PHASE_OFF);
    add_row(any_req(KIND_STOP), 1'b1, PHASE_OFF);
    add_row(byte_req(7, 63, 8'hFF), 1'b1, PHASE_OFF);
    add_row(desc_req(7, 1'b1, 64, 0, 64), 1'b1, PHASE_OFF);
    add_row(note_req(0, 0, 1'b0), 1'b1, PHASE_HELD);
    add_row(any_req(KIND_TICK), 1'b1, PHASE_OFF);
    add_row(note_req(2047, 2047, 1'b1), 1'b1, PHASE_HELD);
    add_row(any_req(KIND_STOP), 1'b1, PHASE_OFF);
    // descriptor corners, then one timed note through release and expiry
    add_row(desc_req(0, 1'b1, 4, 1, 3), 1'b0, PHASE_OFF);
    add_row(desc_req(1, 1'b1, 0, 0, 0), 1'b0, PHASE_OFF);
    add_row(desc_req(2, 1'b1, 64, 63, 64), 1'b0, PHASE_OFF);
    add_row(desc_req(3, 1'b1, 127, 63, 127), 1'b0, PHASE_OFF);
    add_row(desc_req(4, 1'b1, 8, 10, 0), 1'b0, PHASE_OFF);
    add_row(desc_req(5, 1'b1, 64, 0, 64), 1'b0, PHASE_OFF);
    add_row(note_req(4, 9, 1'b1), 1'b0, PHASE_OFF);
    repeat (9) add_row(any_req(KIND_TICK), 1'b0, PHASE_OFF);
  endfunction

  // ------------------------------------------------------------------ drivers

  function automatic int pick_gap();
    int p;
    if (steady_sender) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_request(input voice_req_t r, input bit has_view,
                               input logic [OUT_DATA_W-1:0] view);
    int gap;
    logic [OUT_DATA_W-1:0] want;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {3'b000, r.attack, r.duration_ticks, r.release_ticks, r.release_point,
                 r.loop_point, r.env_length, r.env_enable, r.entry_byte, r.position, r.env_id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = voice_apply(r);
    pending_views.push_back(has_view ? view : want);
    requests_sent++;
  endtask

  // registers are only touched once every result is back
  task automatic settle_voice();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_views.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_UNSIGNED_MASK: pred_mask = val[MASK_W-1:0];
      REG_VOLUME_INDEX:  pred_vol_sel = val[ENV_ID_W-1:0];
      REG_PITCH_INDEX:   pred_pitch_sel = val[ENV_ID_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [TICKS_W-1:0] pick_ticks(input int span);
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return TICKS_W'($urandom_range(0, 2047));
    if (p < 3) return '0;
    return TICKS_W'($urandom_range(1, span));
  endfunction

  // a phrase: maybe reshape some envelopes, start a note, then mostly ticks
  task automatic play_phrase();
    voice_req_t r;
    int n;
    int pick;
    int len;
    n = $urandom_range(0, 3);
    repeat (n) begin
      r = any_req(KIND_LOAD_DESC);
      r.env_id = ($urandom_range(0, 15) == 0) ? '1 : ENV_ID_W'($urandom_range(0, ENVS - 1));
      r.env_enable = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 16);
      else if (pick < 7) len = 0;
      else if (pick < 9) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 127);
      r.env_length = 7'(len);
      if ($urandom_range(0, 3) != 0)
        r.loop_point = 6'($urandom_range(0, len > 63 ? 63 : (len > 0 ? len - 1 : 0)));
      if ($urandom_range(0, 3) != 0)
        r.release_point = 7'($urandom_range(0, len + 1 > 127 ? 127 : len + 1));
      offer_request(r, 1'b0, '0);
    end
    repeat ($urandom_range(0, 3)) offer_request(any_req(KIND_LOAD_BYTE), 1'b0, '0);
    r = note_req(pick_ticks(20), pick_ticks(45), $urandom_range(0, 3) != 0);
    offer_request(r, 1'b0, '0);
    n = $urandom_range(1, 50);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) r = any_req(KIND_STOP + KIND_W'($urandom_range(1, 3)));
      else if (pick < 5) r = any_req(KIND_STOP);
      else if (pick < 8) r = any_req(KIND_LOAD_BYTE);
      else if (pick < 9) r = note_req(pick_ticks(20), pick_ticks(45), 1'b0);
      else r = any_req(KIND_TICK);
      offer_request(r, 1'b0, '0);
    end
  endtask

  // ------------------------------------------------------------ result side

  initial begin : result_sink
    int pick;
    int span;
    bit level;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (stall_wanted && !stall_done) begin
        level = 1'b0;
        span = LONG_STALL;
        stall_done = 1'b1;
      end else if (pick < 55) begin
        level = 1'b1;
        span = $urandom_range(1, 40);
      end else if (pick < 93) begin
        level = 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        level = 1'b0;
        span = $urandom_range(15, 50);
      end
      out_tready <= level;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    logic [OUT_DATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_views.size() == 0) begin
        flag_mismatch("result with no request pending", 0, 0);
      end else begin
        want = pending_views.pop_front();
        if (out_tdata[PHASE_W-1:0] !== want[PHASE_W-1:0])
          flag_mismatch("note_phase", int'(out_tdata[PHASE_W-1:0]), int'(want[PHASE_W-1:0]));
        for (int e = 0; e < OUT_ENVS; e++)
          if (out_tdata[PHASE_W + VALUE_W * e +: VALUE_W] !== want[PHASE_W + VALUE_W * e +: VALUE_W])
            flag_mismatch($sformatf("env_value_%0d", e),
                          int'($signed(out_tdata[PHASE_W + VALUE_W * e +: VALUE_W])),
                          int'($signed(want[PHASE_W + VALUE_W * e +: VALUE_W])));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int goal;
    int phase_start;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_LOAD_BYTE;
    cfg_valid = 1'b0;
    cfg_index = REG_UNSIGNED_MASK;
    cfg_data = '0;
    requests_sent = 0;
    results_checked = 0;
    fail_count = 0;
    settings_used = 1;
    notes_started = 0;
    releases_seen = 0;
    expiries_seen = 0;
    steady_sender = 1'b0;
    stall_wanted = 1'b0;
    stall_done = 1'b0;
    voice_reset();
    build_script();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every entry so no envelope ever reads an unwritten one
    for (int e = 0; e < ENVS; e++)
      for (int p = 0; p < LEN; p++)
        offer_request(byte_req(e, p, p == 1 ? 8'hFF : p == 2 ? 8'h7F : p == 3 ? 8'h80 :
                                     p == 4 ? 8'h00 : 8'($urandom_range(0, 255))),
                      1'b0, '0);

    foreach (script_rows[i])
      offer_request(script_rows[i].req, script_rows[i].has_view, script_rows[i].view);

    for (int ph = 0; ph < PHRASE_PHASES; ph++) begin
      settle_voice();
      if (ph == 0) begin
        write_register(REG_UNSIGNED_MASK, 7'h00);
        write_register(REG_VOLUME_INDEX, 7'd6);
        write_register(REG_PITCH_INDEX, 7'd0);
      end else if (ph == 1) begin
        write_register(REG_UNSIGNED_MASK, 7'h7F);
        write_register(REG_VOLUME_INDEX, 7'h7F);
        write_register(REG_PITCH_INDEX, 7'd7);
        write_register(REG_SPARE, 7'h55);
      end else if (ph == 2) begin
        write_register(REG_UNSIGNED_MASK, 7'h2A);
        write_register(REG_VOLUME_INDEX, 7'd3);
        write_register(REG_PITCH_INDEX, 7'd6);
      end else if (ph == 3) begin
        write_register(REG_UNSIGNED_MASK, 7'(MASK_RESET));
        write_register(REG_VOLUME_INDEX, 7'(VOL_RESET));
        write_register(REG_PITCH_INDEX, 7'(PITCH_RESET));
      end else begin
        write_register(REG_UNSIGNED_MASK, 7'($urandom_range(0, 127)));
        write_register(REG_VOLUME_INDEX, 7'($urandom_range(0, 127)));
        write_register(REG_PITCH_INDEX, 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 3) == 0) write_register(REG_SPARE, 7'($urandom_range(0, 127)));
      end
      settings_used++;
      steady_sender = (ph == 2 || ph == 7);
      phase_start = requests_sent;
      goal = requests_sent + ITEMS_PER_PHASE;
      while (requests_sent < goal) begin
        // long result back-pressure while requests keep coming
        if (ph == 4 && requests_sent >= phase_start + 10) stall_wanted = 1'b1;
        play_phrase();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results for %0d requests across %0d register settings",
             results_checked, requests_sent, settings_used);
    $display("notes started %0d, timer releases %0d, duration expiries %0d",
             notes_started, releases_seen, expiries_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
